[rtl/ldc_pkg.sv]
// Shared types for the longest dominance chain block.
`default_nettype none
package ldc_pkg;

  // Result of one pair comparison, from the compare pipe to the sequencer.
  typedef struct packed {
    logic vld;   // result present this cycle
    logic busy;  // any stage occupied
    logic fwd;   // stored item i precedes item j
    logic bwd;   // item j precedes stored item i
  } prec_t;

endpackage
`default_nettype wire

[rtl/ldc_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ldc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/ldc_cmp.sv]
// Two-stage pipe deciding precedence both ways between two quadratics.
`default_nettype none
module ldc_cmp #(
  parameter int W  = 16,
  parameter int IW = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_vld,
  input  wire logic [IW-1:0]        in_idx,
  input  wire logic signed [W-1:0]  ai,
  input  wire logic signed [W-1:0]  bi,
  input  wire logic signed [W-1:0]  ci,
  input  wire logic signed [W-1:0]  aj,
  input  wire logic signed [W-1:0]  bj,
  input  wire logic signed [W-1:0]  cj,
  output ldc_pkg::prec_t            res,
  output logic [IW-1:0]             res_idx
);
  import ldc_pkg::*;

  localparam int DW = 2 * W + 5;

  // stage 1: differences and flags
  logic              s1_vld_r;
  logic [IW-1:0]     s1_idx_r;
  logic signed [W:0] da_r, db_r, dc_r;
  logic              a_lt_r, a_eq_r, b_eq_r, c_lt_r, c_gt_r;
  // stage 2: products
  logic                  s2_vld_r;
  logic [IW-1:0]         s2_idx_r;
  logic signed [2*W+1:0] sq_r, pr_r;
  logic                  a_lt2_r, a_eq2_r, b_eq2_r, c_lt2_r, c_gt2_r;
  logic signed [DW-1:0]  disc;
  logic                  neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
    s1_idx_r <= in_idx;
    da_r     <= {aj[W-1], aj} - {ai[W-1], ai};
    db_r     <= {bj[W-1], bj} - {bi[W-1], bi};
    dc_r     <= {cj[W-1], cj} - {ci[W-1], ci};
    a_lt_r   <= ai < aj;
    a_eq_r   <= ai == aj;
    b_eq_r   <= bi == bj;
    c_lt_r   <= ci < cj;
    c_gt_r   <= ci > cj;
    s2_idx_r <= s1_idx_r;
    sq_r     <= db_r * db_r;
    pr_r     <= da_r * dc_r;
    a_lt2_r  <= a_lt_r;
    a_eq2_r  <= a_eq_r;
    b_eq2_r  <= b_eq_r;
    c_lt2_r  <= c_lt_r;
    c_gt2_r  <= c_gt_r;
  end

  // discriminant sign is the same for both orderings
  assign disc = DW'(sq_r) - (DW'(pr_r) <<< 2);
  assign neg  = disc[DW-1];

  always_comb begin
    res.vld  = s2_vld_r;
    res.busy = s1_vld_r | s2_vld_r;
    res.fwd  = (a_lt2_r & neg) | (a_eq2_r & b_eq2_r & c_lt2_r);
    res.bwd  = (~a_lt2_r & ~a_eq2_r & neg) | (a_eq2_r & b_eq2_r & c_gt2_r);
  end
  assign res_idx = s2_idx_r;

endmodule
`default_nettype wire

[rtl/longest_dominance_chain_per_item.sv]
// Top level: load quadratics, build precedence matrix, Kahn passes, emit chains.
// Sequence: after the last item the matrix is built row by row; a forward and a backward Kahn
//   pass follow, each visiting every queued item and its edges; then one result per item is emitted.
// Throughput: one input transaction per cycle while loading; input stalls from the last item
//   until its final result is loaded into the output register.
// Reset: synchronous active-low rst_n clears sequencer, item count and valids; memories are not.
`default_nettype none
module longest_dominance_chain_per_item #(
  parameter int MAX_ITEMS = 64,
  parameter int COEF_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [COEF_BITS-1:0] in_coef_a,
  input  wire logic [COEF_BITS-1:0] in_coef_b,
  input  wire logic [COEF_BITS-1:0] in_coef_c,
  input  wire logic                 in_last_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [5:0]                out_item_index,
  output logic [6:0]                out_chain_length,
  output logic                      out_last_result
);
  import ldc_pkg::*;

  localparam int N  = MAX_ITEMS;
  localparam int W  = COEF_BITS;
  localparam int IW = (N > 1) ? $clog2(N) : 1;   // entry index
  localparam int CW = $clog2(N + 1);             // counts and chain lengths

  // sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RI      = 4'd1;   // read row item
  localparam logic [3:0] S_LI      = 4'd2;   // latch row item
  localparam logic [3:0] S_SWEEP   = 4'd3;   // stream column items into compare pipe
  localparam logic [3:0] S_DRAIN   = 4'd4;
  localparam logic [3:0] S_WROW    = 4'd5;   // write row, column and degrees
  localparam logic [3:0] S_INIT_RD = 4'd6;
  localparam logic [3:0] S_INIT_WR = 4'd7;
  localparam logic [3:0] S_Q_RD    = 4'd8;   // pop ready queue
  localparam logic [3:0] S_Q_LD    = 4'd9;
  localparam logic [3:0] S_Q_HOLD  = 4'd10;
  localparam logic [3:0] S_J_SCAN  = 4'd11;
  localparam logic [3:0] S_J_WR    = 4'd12;
  localparam logic [3:0] S_E_RD    = 4'd13;
  localparam logic [3:0] S_E_OUT   = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] tail_r, tail_nxt;
  logic          dir_r, dir_nxt;      // 1: forward pass
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r;
  logic [N-1:0]  row_r, row_nxt;
  logic [N-1:0]  col_r, col_nxt;
  logic [CW-1:0] ic_r, ic_nxt;        // in-degree of row item
  logic [CW-1:0] oc_r, oc_nxt;        // out-degree of row item
  logic [CW-1:0] chain_a_r, chain_a_nxt;
  logic [N-1:0]  adj_r, adj_nxt;
  logic [3*W-1:0] ci_r, ci_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    out_idx_r, out_idx_nxt;
  logic [6:0]    out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;

  // memory ports
  logic           coef_we;
  logic [IW-1:0]  coef_raddr;
  logic [3*W-1:0] coef_rdata;
  logic           mat_we;
  logic [N-1:0]   m_rdata, mt_rdata;
  logic [IW-1:0]  adj_raddr;
  logic           pf_we, pb_we;
  logic [CW-1:0]  pf_wdata, pb_wdata, pf_rdata, pb_rdata, pend_rd, pend_new;
  logic           ce_we, cs_we;
  logic [IW-1:0]  chain_waddr, chain_raddr;
  logic [CW-1:0]  chain_wdata, ce_rdata, cs_rdata, chain_rd, chain_inc;
  logic           q_we;
  logic [IW-1:0]  q_rdata;
  prec_t          res;
  logic [IW-1:0]  res_idx;
  logic           in_acc;
  logic [CW:0]    len_sum;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  ldc_ram #(.WIDTH(3 * W), .DEPTH(N)) u_coef (
    .clk(clk), .we(coef_we), .waddr(cnt_r[IW-1:0]),
    .wdata({in_coef_a, in_coef_b, in_coef_c}), .raddr(coef_raddr), .rdata(coef_rdata));

  // row i bit j: i precedes j; transposed copy: row i bit j: j precedes i
  ldc_ram #(.WIDTH(N), .DEPTH(N)) u_mat (
    .clk(clk), .we(mat_we), .waddr(i_r[IW-1:0]), .wdata(row_r),
    .raddr(adj_raddr), .rdata(m_rdata));
  ldc_ram #(.WIDTH(N), .DEPTH(N)) u_mat_t (
    .clk(clk), .we(mat_we), .waddr(i_r[IW-1:0]), .wdata(col_r),
    .raddr(adj_raddr), .rdata(mt_rdata));

  // pending predecessors (forward) and successors (backward)
  ldc_ram #(.WIDTH(CW), .DEPTH(N)) u_pend_f (
    .clk(clk), .we(pf_we), .waddr(mat_we ? i_r[IW-1:0] : j_r[IW-1:0]), .wdata(pf_wdata),
    .raddr(j_r[IW-1:0]), .rdata(pf_rdata));
  ldc_ram #(.WIDTH(CW), .DEPTH(N)) u_pend_b (
    .clk(clk), .we(pb_we), .waddr(mat_we ? i_r[IW-1:0] : j_r[IW-1:0]), .wdata(pb_wdata),
    .raddr(j_r[IW-1:0]), .rdata(pb_rdata));

  ldc_ram #(.WIDTH(CW), .DEPTH(N)) u_chain_e (
    .clk(clk), .we(ce_we), .waddr(chain_waddr), .wdata(chain_wdata),
    .raddr(chain_raddr), .rdata(ce_rdata));
  ldc_ram #(.WIDTH(CW), .DEPTH(N)) u_chain_s (
    .clk(clk), .we(cs_we), .waddr(chain_waddr), .wdata(chain_wdata),
    .raddr(chain_raddr), .rdata(cs_rdata));

  ldc_ram #(.WIDTH(IW), .DEPTH(N)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail_r[IW-1:0]), .wdata(j_r[IW-1:0]),
    .raddr(head_r[IW-1:0]), .rdata(q_rdata));

  ldc_cmp #(.W(W), .IW(IW)) u_cmp (
    .clk(clk), .rst_n(rst_n), .in_vld(rd_vld_r), .in_idx(rd_idx_r),
    .ai(ci_r[3*W-1:2*W]), .bi(ci_r[2*W-1:W]), .ci(ci_r[W-1:0]),
    .aj(coef_rdata[3*W-1:2*W]), .bj(coef_rdata[2*W-1:W]), .cj(coef_rdata[W-1:0]),
    .res(res), .res_idx(res_idx));

  // shared address and data paths
  assign coef_we    = in_acc & (cnt_r < CW'(N));
  assign coef_raddr = (state_r == S_RI) ? i_r[IW-1:0] : j_r[IW-1:0];
  assign mat_we     = (state_r == S_WROW);
  assign adj_raddr  = q_rdata;
  assign pend_rd    = dir_r ? pf_rdata : pb_rdata;
  assign chain_rd   = dir_r ? ce_rdata : cs_rdata;
  assign pend_new   = (pend_rd != '0) ? pend_rd - CW'(1) : pend_rd;
  assign chain_inc  = chain_a_r + CW'(1);
  assign chain_waddr = j_r[IW-1:0];
  assign len_sum    = {1'b0, ce_rdata} + {1'b0, cs_rdata} - (CW + 1)'(1);

  always_comb begin
    unique case (state_r)
      S_Q_LD:          chain_raddr = q_rdata;
      S_E_RD, S_E_OUT: chain_raddr = i_r[IW-1:0];
      default:         chain_raddr = j_r[IW-1:0];
    endcase
  end

  // degrees are written at row end; pending counts updated during the passes
  always_comb begin
    pf_we    = mat_we | (dir_r & (state_r == S_J_WR));
    pb_we    = mat_we | (~dir_r & (state_r == S_J_WR));
    pf_wdata = mat_we ? ic_r : pend_new;
    pb_wdata = mat_we ? oc_r : pend_new;
    ce_we    = dir_r & ((state_r == S_INIT_WR) | (state_r == S_J_WR));
    cs_we    = ~dir_r & ((state_r == S_INIT_WR) | (state_r == S_J_WR));
    chain_wdata = (state_r == S_INIT_WR) ? CW'(1) :
                  ((chain_inc > chain_rd) ? chain_inc : chain_rd);
    q_we = 1'b0;
    if (state_r == S_INIT_WR) begin
      q_we = (pend_rd == '0) & (tail_r < CW'(N));
    end else if (state_r == S_J_WR) begin
      q_we = (pend_new == '0) & (tail_r < CW'(N));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    dir_nxt       = dir_r;
    rd_vld_nxt    = 1'b0;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ic_nxt        = ic_r;
    oc_nxt        = oc_r;
    chain_a_nxt   = chain_a_r;
    adj_nxt       = adj_r;
    ci_nxt        = ci_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_idx_nxt   = out_idx_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    // compare results land in the row and column registers
    if (res.vld) begin
      row_nxt[res_idx] = res.fwd;
      col_nxt[res_idx] = res.bwd;
      oc_nxt = oc_r + CW'(res.fwd);
      ic_nxt = ic_r + CW'(res.bwd);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt = (cnt_r < CW'(N)) ? cnt_r + CW'(1) : cnt_r;
          if (in_last_item) begin
            n_nxt     = cnt_nxt;
            i_nxt     = '0;
            state_nxt = S_RI;
          end
        end
      end
      S_RI: begin
        row_nxt   = '0;
        col_nxt   = '0;
        ic_nxt    = '0;
        oc_nxt    = '0;
        state_nxt = S_LI;
      end
      S_LI: begin
        ci_nxt    = coef_rdata;
        j_nxt     = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        rd_vld_nxt = 1'b1;
        j_nxt      = j_r + CW'(1);
        if (j_nxt == n_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !res.busy) begin
          state_nxt = S_WROW;
        end
      end
      S_WROW: begin
        i_nxt = i_r + CW'(1);
        if (i_nxt == n_r) begin
          dir_nxt   = 1'b1;
          j_nxt     = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = S_INIT_RD;
        end else begin
          state_nxt = S_RI;
        end
      end
      S_INIT_RD: begin
        state_nxt = S_INIT_WR;
      end
      S_INIT_WR: begin
        if (q_we) begin
          tail_nxt = tail_r + CW'(1);
        end
        j_nxt = j_r + CW'(1);
        state_nxt = (j_nxt == n_r) ? S_Q_RD : S_INIT_RD;
      end
      S_Q_RD: begin
        if (head_r == tail_r) begin
          if (dir_r) begin
            dir_nxt   = 1'b0;
            j_nxt     = '0;
            head_nxt  = '0;
            tail_nxt  = '0;
            state_nxt = S_INIT_RD;
          end else begin
            i_nxt     = '0;
            state_nxt = S_E_RD;
          end
        end else begin
          state_nxt = S_Q_LD;
        end
      end
      S_Q_LD: begin
        head_nxt  = head_r + CW'(1);
        state_nxt = S_Q_HOLD;
      end
      S_Q_HOLD: begin
        adj_nxt     = dir_r ? m_rdata : mt_rdata;
        chain_a_nxt = chain_rd;
        j_nxt       = '0;
        state_nxt   = S_J_SCAN;
      end
      S_J_SCAN: begin
        if (j_r == n_r) begin
          state_nxt = S_Q_RD;
        end else if (adj_r[j_r[IW-1:0]]) begin
          state_nxt = S_J_WR;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      S_J_WR: begin
        if (q_we) begin
          tail_nxt = tail_r + CW'(1);
        end
        j_nxt     = j_r + CW'(1);
        state_nxt = S_J_SCAN;
      end
      S_E_RD: begin
        state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 6'(i_r);
          out_len_nxt   = 7'(len_sum);
          out_last_nxt  = (i_r + CW'(1) == n_r);
          i_nxt         = i_r + CW'(1);
          if (i_nxt == n_r) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_E_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    dir_r     <= dir_nxt;
    rd_idx_r  <= j_r[IW-1:0];
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    ic_r      <= ic_nxt;
    oc_r      <= oc_nxt;
    chain_a_r <= chain_a_nxt;
    adj_r     <= adj_nxt;
    ci_r      <= ci_nxt;
    out_idx_r <= out_idx_nxt;
    out_len_r <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_item_index   = out_idx_r;
  assign out_chain_length = out_len_r;
  assign out_last_result  = out_last_r;

endmodule
`default_nettype wire

[bench/longest_dominance_chain_per_item_tb.sv]
// Testbench for the longest dominance chain block: random quadratic sets, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module longest_dominance_chain_per_item_tb;

  localparam int NMAX = 64;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic        last;
  } quad_t;

  typedef struct packed {
    logic [5:0] idx;
    logic [6:0] len;
    logic       last;
  } chain_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_coef_a = '0;
  logic [15:0] in_coef_b = '0;
  logic [15:0] in_coef_c = '0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_item_index;
  logic [6:0]  out_chain_length;
  logic        out_last_result;

  longest_dominance_chain_per_item dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .in_last_item(in_last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_item_index(out_item_index), .out_chain_length(out_chain_length),
    .out_last_result(out_last_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quad_t  pending_quads[$];
  chain_t expected_chains[$];
  int     error_count = 0;
  int     send_idle_pct = 10;
  int     recv_idle_pct = 67;
  int     hold_cycles = 0;   // long receiver hold-off, counted down by its own process
  bit     in_taken = 0;      // input transaction accepted at the last rising edge

  // Predictor state: a model copy of the loaded set.
  logic signed [15:0] set_a[NMAX], set_b[NMAX], set_c[NMAX];
  int                 set_count = 0;

  function automatic bit dominates(int i, int j);
    longint da, db, dc;
    if (set_a[i] > set_a[j]) return 0;
    if (set_a[i] == set_a[j]) return set_b[i] == set_b[j] && set_c[i] < set_c[j];
    da = longint'(set_a[j]) - set_a[i];
    db = longint'(set_b[j]) - set_b[i];
    dc = longint'(set_c[j]) - set_c[i];
    return db * db - 4 * da * dc < 0;
  endfunction

  // Longest chains by Kahn order in both directions; queues one result per item.
  task automatic predict_chains();
    bit prec[NMAX][NMAX];
    int deg[NMAX], fwd[NMAX], bwd[NMAX], order[$];
    int n, u;
    chain_t r;
    n = set_count;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) prec[i][j] = dominates(i, j);
    for (int dir = 0; dir < 2; dir++) begin
      order.delete();
      for (int i = 0; i < n; i++) begin
        deg[i] = 0;
        if (dir == 0) fwd[i] = 1; else bwd[i] = 1;
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (prec[i][j]) begin
            if (dir == 0) deg[j]++; else deg[i]++;
          end
      for (int i = 0; i < n; i++) if (deg[i] == 0) order = {order, i};
      for (int h = 0; h < order.size(); h++) begin
        u = order[h];
        for (int j = 0; j < n; j++)
          if (dir == 0 ? prec[u][j] : prec[j][u]) begin
            if (deg[j] > 0) deg[j]--;
            if (dir == 0) begin
              if (fwd[u] + 1 > fwd[j]) fwd[j] = fwd[u] + 1;
            end else begin
              if (bwd[u] + 1 > bwd[j]) bwd[j] = bwd[u] + 1;
            end
            if (deg[j] == 0) order = {order, j};
          end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.idx = i[5:0];
      r.len = 7'(fwd[i] + bwd[i] - 1);
      r.last = (i + 1 == n);
      expected_chains = {expected_chains, r};
    end
    set_count = 0;
  endtask

  // Accepted input transaction goes into the predictor.
  task automatic load_quad(quad_t q);
    if (set_count < NMAX) begin
      set_a[set_count] = q.a;
      set_b[set_count] = q.b;
      set_c[set_count] = q.c;
      set_count++;
    end
    if (q.last) predict_chains();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: payload held until taken, changes at the falling edge only.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_quads.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          quad_t q;
          q = pending_quads.pop_front();
          in_valid <= 1'b1;
          in_coef_a <= q.a;
          in_coef_b <= q.b;
          in_coef_c <= q.c;
          in_last_item <= q.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_cycles > 0) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(negedge clk) if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

  // Monitor: both channels sampled at the rising edge.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      load_quad({in_coef_a, in_coef_b, in_coef_c, in_last_item});
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chains.size() == 0) begin
        report_mismatch("unexpected result, index", out_item_index, -1);
      end else begin
        chain_t w;
        w = expected_chains.pop_front();
        if (out_item_index !== w.idx) report_mismatch("item_index", out_item_index, w.idx);
        if (out_chain_length !== w.len)
          report_mismatch("chain_length", out_chain_length, w.len);
        if (out_last_result !== w.last)
          report_mismatch("last_result", out_last_result, w.last);
      end
    end
  end

  function automatic quad_t mk(int a, int b, int c, bit last);
    quad_t q;
    q.a = a[15:0]; q.b = b[15:0]; q.c = c[15:0]; q.last = last;
    return q;
  endfunction

  task automatic add_quad(quad_t q);
    pending_quads = {pending_quads, q};
  endtask

  // Small coefficient range gives plenty of edges; full range covers every bit.
  function automatic int rnd_coef(bit narrow);
    if (narrow) return $urandom_range(6) - 3;
    return $urandom_range(16'hffff);
  endfunction

  task automatic queue_set(int n, bit narrow);
    for (int i = 0; i < n; i++)
      add_quad(mk(rnd_coef(narrow), rnd_coef(narrow), rnd_coef(narrow), i == n - 1));
  endtask

  task automatic drain();
    while (pending_quads.size() > 0 || in_valid || expected_chains.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: single item, extremes, equal a and b with ordered c, a chain.
    add_quad(mk(0, 0, 0, 1));
    add_quad(mk(-32768, -32768, -32768, 0));
    add_quad(mk(32767, 32767, 32767, 0));
    add_quad(mk(-32768, 32767, -32768, 0));
    add_quad(mk(32767, -32768, 32767, 0));
    add_quad(mk(5, 2, 1, 0));
    add_quad(mk(5, 2, 9, 0));
    add_quad(mk(5, 2, 9, 0));
    add_quad(mk(0, 0, 0, 0));
    add_quad(mk(1, 0, 1, 0));
    add_quad(mk(2, 0, 2, 0));
    add_quad(mk(3, 0, 3, 1));
    drain();

    // Capacity: 66 items, the last two dropped, the final one still starts the run.
    queue_set(66, 1);
    drain();

    // Long receiver hold-off while the sender keeps going into the next set.
    hold_cycles = 3000;
    queue_set(8, 1);
    queue_set(6, 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 67; recv_idle_pct = 10; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int s = 0; s < 6; s++) queue_set($urandom_range(12, 1), $urandom_range(3) != 0);
      drain();
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("longest_dominance_chain_per_item test passed");
    else $display("longest_dominance_chain_per_item test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("longest_dominance_chain_per_item test failed");
    $finish;
  end

endmodule
`default_nettype wire
